@@ src/bur_pkg.sv @@
// types and constants shared by the undo/redo history block
package bur_pkg;

    typedef enum logic [1:0] {
        OP_PUSH  = 2'd0,
        OP_UNDO  = 2'd1,
        OP_REDO  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NO_UNDO = 2'd1;
    localparam logic [1:0] STAT_NO_REDO = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_READ
    } state_t;

    typedef struct packed {
        logic [1:0]  operation;
        logic [31:0] before_recipe;
        logic [31:0] after_recipe;
    } req_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] recipe_out;
        logic        undo_possible;
        logic        redo_possible;
        logic [6:0]  entries_held;
        logic [6:0]  cursor_position;
    } rsp_item_t;

endpackage

@@ src/bur_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
module bur_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ src/bounded_undo_redo_history_top.sv @@
// bounded undo/redo history: ring of before/after entries with a cursor
//
//  channel | valid     | stall     | payload
//  --------+-----------+-----------+------------------------------
//  request | req_valid | req_stall | req (operation, before, after)
//  result  | rsp_valid | rsp_stall | rsp (status, recipe, counts)
//
// push, clear and refused undo/redo: the result beat is registered at the
// accept edge. a good undo or redo first does the synchronous read of the
// entry ram, then loads the result register from the read state once it is free.
// a request is taken only in idle and when the result register frees up.
// reset clears the state, pointers, counts and result valid; the ram keeps no reset.
module bounded_undo_redo_history_top
    import bur_pkg::*;
#(
    parameter int DEPTH       = 64,
    parameter int RECIPE_BITS = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_stall,
    input  req_item_t req,
    output logic      rsp_valid,
    input  logic      rsp_stall,
    output rsp_item_t rsp
);

    localparam int SW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int RB = RECIPE_BITS;

    state_t          state_reg, state_next;
    logic [SW-1:0]   oldest_reg, oldest_next;
    logic [CW-1:0]   count_reg, count_next;
    logic [CW-1:0]   applied_reg, applied_next;
    logic            rsp_valid_reg;
    rsp_item_t       rsp_reg;
    rsp_item_t       pend_reg, pend_next;
    rsp_item_t       read_rsp;
    logic            redo_reg;

    logic            accept;
    logic            out_free;
    logic            load_direct;
    logic            load_read;
    logic            need_read;
    op_t             op;

    logic [CW-1:0]   offset;
    logic [CW:0]     ring_sum;
    logic [SW-1:0]   slot;
    logic [SW-1:0]   oldest_inc;

    logic            wr_en;
    logic            rd_en;
    logic [2*RB-1:0] wr_word;
    logic [2*RB-1:0] rd_word;
    logic [RB+31:0]  before_ext;
    logic [RB+31:0]  after_ext;
    logic [RB+31:0]  recipe_ext;
    logic [CW+6:0]   count_ext;
    logic [CW+6:0]   applied_ext;
    logic [1:0]      status;

    assign op       = op_t'(req.operation);
    assign out_free = !rsp_valid_reg || !rsp_stall;
    assign accept   = req_valid && !req_stall;

    // ring slot of oldest + offset, sum stays below twice the depth
    always_comb
    begin
        offset = applied_reg;
        if (op == OP_UNDO)
        begin
            offset = applied_reg - CW'(1);
        end
        else if (op == OP_PUSH && applied_reg == CW'(DEPTH))
        begin
            offset = '0;
        end
        ring_sum = (CW + 1)'(oldest_reg) + (CW + 1)'(offset);
        if (ring_sum >= (CW + 1)'(DEPTH))
        begin
            ring_sum = ring_sum - (CW + 1)'(DEPTH);
        end
        slot = ring_sum[SW-1:0];
    end

    assign oldest_inc = (oldest_reg == SW'(DEPTH - 1)) ? '0 : oldest_reg + SW'(1);

    // pointer update and result fields for the accepted beat
    always_comb
    begin
        oldest_next  = oldest_reg;
        count_next   = count_reg;
        applied_next = applied_reg;
        status       = STAT_OK;
        need_read    = 1'b0;
        wr_en        = 1'b0;
        case (op)
            OP_PUSH:
            begin
                wr_en = 1'b1;
                if (applied_reg < CW'(DEPTH))
                begin
                    count_next   = applied_reg + CW'(1);
                    applied_next = applied_reg + CW'(1);
                end
                else
                begin
                    oldest_next  = oldest_inc;
                    count_next   = CW'(DEPTH);
                    applied_next = CW'(DEPTH);
                end
            end
            OP_UNDO:
            begin
                if (applied_reg == '0)
                begin
                    status = STAT_NO_UNDO;
                end
                else
                begin
                    need_read    = 1'b1;
                    applied_next = applied_reg - CW'(1);
                end
            end
            OP_REDO:
            begin
                if (applied_reg >= count_reg)
                begin
                    status = STAT_NO_REDO;
                end
                else
                begin
                    need_read    = 1'b1;
                    applied_next = applied_reg + CW'(1);
                end
            end
            default:
            begin
                oldest_next  = '0;
                count_next   = '0;
                applied_next = '0;
            end
        endcase

        count_ext   = (CW + 7)'(count_next);
        applied_ext = (CW + 7)'(applied_next);

        pend_next.status          = status;
        pend_next.recipe_out      = '0;
        pend_next.undo_possible   = (applied_next != '0);
        pend_next.redo_possible   = (applied_next < count_next);
        pend_next.entries_held    = count_ext[6:0];
        pend_next.cursor_position = applied_ext[6:0];
    end

    assign before_ext = (RB + 32)'(req.before_recipe);
    assign after_ext  = (RB + 32)'(req.after_recipe);
    assign wr_word    = {before_ext[RB-1:0], after_ext[RB-1:0]};
    assign rd_en      = accept && need_read;

    // entry layout: before word high, after word low
    bur_ram #(
        .WIDTH (2 * RB),
        .DEPTH (DEPTH)
    ) u_entry_ram (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr (slot),
        .wr_data (wr_word),
        .rd_en   (rd_en),
        .rd_addr (slot),
        .rd_data (rd_word)
    );

    assign recipe_ext = redo_reg ? (RB + 32)'(rd_word[RB-1:0])
                                 : (RB + 32)'(rd_word[2*RB-1:RB]);

    always_comb
    begin
        read_rsp            = pend_reg;
        read_rsp.recipe_out = recipe_ext[31:0];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && need_read)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // fsm outputs
    always_comb
    begin
        req_stall   = 1'b1;
        load_direct = 1'b0;
        load_read   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall   = !out_free;
                load_direct = accept && !need_read;
            end
            ST_READ:
            begin
                load_read = out_free;
            end
            default:
            begin
                req_stall = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            oldest_reg    <= '0;
            count_reg     <= '0;
            applied_reg   <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (accept)
            begin
                oldest_reg  <= oldest_next;
                count_reg   <= count_next;
                applied_reg <= applied_next;
            end
            if (load_direct || load_read)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            pend_reg <= pend_next;
            redo_reg <= (op == OP_REDO);
        end
        if (load_direct)
        begin
            rsp_reg <= pend_next;
        end
        else if (load_read)
        begin
            rsp_reg <= read_rsp;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule
